[design/tabular_q_learning_level_agent_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the level agent
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_LEVEL_AGENT_DEFINES_SVH
`define TABULAR_Q_LEARNING_LEVEL_AGENT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TQLLA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TQLLA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tqlla_pkg.sv]
// ----------------------------------------------------------------------------
// tqlla_pkg
// Types, codes and constants of the Q-learning level agent.
// ----------------------------------------------------------------------------
package tqlla_pkg;

  // Default sizing
  localparam int MAX_LEVELS_DEF = 64;
  localparam int Q_WIDTH_DEF    = 24;

  // Fraction format of alpha, gamma and epsilon
  localparam int FRAC_SHIFT = 16;
  localparam int FRAC_W     = 17;
  localparam int FRAC_HALF  = 32768;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  // Field widths
  localparam int REWARD_W     = 18;
  localparam int RAND_W       = 16;
  localparam int LEVEL_OUT_W  = 6;
  localparam int ACTION_W     = 2;
  localparam int BEST_Q_W     = 24;
  localparam int DRIVE_W      = 32;
  localparam int NUM_LEVELS_W = 7;
  localparam int Q_INIT_W     = 24;
  localparam int INIT_LEVEL_W = 6;
  localparam int OMEGA_STEP_W = 31;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE,
    CFG_DISCOUNT,
    CFG_EXPLORE,
    CFG_NUM_LEVELS,
    CFG_Q_INITIAL,
    CFG_INIT_LEVEL,
    CFG_OMEGA_MIN,
    CFG_OMEGA_STEP
  } cfg_index_t;

  // Register reset values
  localparam logic [FRAC_W-1:0]       LEARN_RATE_RST = 17'd32768;
  localparam logic [FRAC_W-1:0]       DISCOUNT_RST   = 17'd58982;
  localparam logic [FRAC_W-1:0]       EXPLORE_RST    = 17'd6554;
  localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RST = 7'd64;
  localparam logic [OMEGA_STEP_W-1:0] OMEGA_STEP_RST = 31'd65536;

  // Random pick thresholds: p < 1/2, p < 1/3, p < 2/3 on a 16-bit value
  localparam logic [RAND_W-1:0] PICK_HALF       = 16'd32768;
  localparam logic [RAND_W-1:0] PICK_THIRD      = 16'((65536 + 2) / 3);
  localparam logic [RAND_W-1:0] PICK_TWO_THIRDS = 16'((2 * 65536 + 2) / 3);

  typedef enum logic [ACTION_W-1:0] {
    ACT_DOWN = 2'd0,
    ACT_HOLD = 2'd1,
    ACT_UP   = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_INIT_OUT,
    ST_FILL,
    ST_ROW,
    ST_PREV,
    ST_TGT,
    ST_DIFF,
    ST_MULA,
    ST_WB
  } state_t;

endpackage

[design/tqlla_ram.sv]
// ----------------------------------------------------------------------------
// tqlla_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tqlla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/tabular_q_learning_level_agent.sv]
// ----------------------------------------------------------------------------
// tabular_q_learning_level_agent
// Epsilon-greedy tabular Q-learning agent stepping along a ladder of levels.
// ----------------------------------------------------------------------------
// The Q table holds one row per ladder level (down, hold, up entries) in a
// single RAM with one write and one registered read port, one row per word.
// The first transfer after reset passes the init states and loads its
// result once the output register is free, then loads q_initial into the
// table at one row per cycle, during which no item is taken. Every later
// item goes from transfer in to a loaded result through the greedy search
// on the current row, the previous row read with the gamma multiply, the
// target add and saturate, the difference, the alpha multiply, then the
// add, saturate and row write-back. A stalled result holds the write-back
// until the output register frees. One item is in flight at a time; the
// next is taken on the cycle after write-back, while the result may still
// sit in the output register.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`include "tabular_q_learning_level_agent_defines.svh"

module tabular_q_learning_level_agent #(
  parameter int MAX_LEVELS = tqlla_pkg::MAX_LEVELS_DEF,
  parameter int Q_WIDTH    = tqlla_pkg::Q_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [tqlla_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tqlla_pkg::CFG_DATA_W-1:0]         cfg_data,
  // decision items
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [tqlla_pkg::REWARD_W-1:0]    reward_value,
  input  logic [tqlla_pkg::RAND_W-1:0]             rand_explore,
  input  logic [tqlla_pkg::RAND_W-1:0]             rand_pick,
  // results
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [tqlla_pkg::LEVEL_OUT_W-1:0]        new_level,
  output logic [tqlla_pkg::ACTION_W-1:0]           chosen_action,
  output logic                                     was_greedy,
  output logic                                     was_first,
  output logic signed [tqlla_pkg::BEST_Q_W-1:0]    best_q,
  output logic signed [tqlla_pkg::DRIVE_W-1:0]     drive_value
);

  import tqlla_pkg::*;

  localparam int LW    = $clog2(MAX_LEVELS);
  localparam int CW    = (LW + 1 > NUM_LEVELS_W) ? LW + 1 : NUM_LEVELS_W;
  localparam int ROW_W = 3 * Q_WIDTH;
  localparam int EW    = (Q_WIDTH > Q_INIT_W) ? Q_WIDTH : Q_INIT_W;
  localparam int UW    = Q_WIDTH + 4;
  localparam int PGW   = Q_WIDTH + FRAC_W;
  localparam int PAW   = Q_WIDTH + 1 + FRAC_W;
  localparam int DPW   = LW + OMEGA_STEP_W;
  localparam int DW    = DPW + 2;

  localparam logic [LW-1:0] FILL_LAST = LW'(MAX_LEVELS - 1);

  localparam logic signed [EW-1:0] QI_MAX = EW'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] QI_MIN = EW'(-(64'sd1 <<< (Q_WIDTH - 1)));
  localparam logic signed [UW-1:0] QU_MAX = UW'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
  localparam logic signed [UW-1:0] QU_MIN = UW'(-(64'sd1 <<< (Q_WIDTH - 1)));
  localparam logic signed [DW-1:0] DRV_MAX = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] DRV_MIN = DW'(-64'sd2147483648);

  // configuration registers
  logic [FRAC_W-1:0]              cfg_learn_rate;
  logic [FRAC_W-1:0]              cfg_discount;
  logic [FRAC_W-1:0]              cfg_explore;
  logic [NUM_LEVELS_W-1:0]        cfg_num_levels;
  logic signed [Q_INIT_W-1:0]     cfg_q_initial;
  logic [INIT_LEVEL_W-1:0]        cfg_init_level;
  logic signed [DRIVE_W-1:0]      cfg_omega_min;
  logic [OMEGA_STEP_W-1:0]        cfg_omega_step;

  // control state
  state_t                         state;
  state_t                         state_next;
  logic                           first_pending;
  logic [LW-1:0]                  prev_level;
  action_t                        prev_action;
  logic                           load_out;
  logic                           out_slot_free;
  logic                           in_take;

  // datapath registers
  logic signed [REWARD_W-1:0]     reward_reg;
  logic [RAND_W-1:0]              rexp_reg;
  logic [RAND_W-1:0]              rpick_reg;
  logic [LW-1:0]                  level_reg;
  logic [LW-1:0]                  nlev_reg;
  action_t                        act_reg;
  logic                           greedy_flag;
  logic                           first_flag;
  logic signed [Q_WIDTH-1:0]      best_reg;
  logic signed [Q_WIDTH-1:0]      q0_reg;
  logic [LW-1:0]                  fill_cnt;
  logic [ROW_W-1:0]               prev_row_reg;
  logic [PGW-1:0]                 prod_g;
  logic                           best_neg;
  logic signed [Q_WIDTH-1:0]      target_reg;
  logic signed [Q_WIDTH:0]        diff_reg;
  logic [PAW-1:0]                 prod_a;
  logic                           diff_neg;
  logic [DPW-1:0]                 drive_prod;

  // combinational
  logic [CW-1:0]                  nl_ext;
  logic [CW-1:0]                  il_ext;
  logic [LW-1:0]                  top_level;
  logic [LW-1:0]                  start_level;
  logic [LW:0]                    move_sum;
  logic [LW:0]                    move_dec;
  logic [LW-1:0]                  move_level;
  logic signed [EW-1:0]           qi_ext;
  logic signed [Q_WIDTH-1:0]      q_init_sat;
  logic [FRAC_W-1:0]              alpha;
  logic [FRAC_W-1:0]              gamma;
  logic signed [Q_WIDTH-1:0]      q_r0;
  logic signed [Q_WIDTH-1:0]      q_r1;
  logic signed [Q_WIDTH-1:0]      q_r2;
  logic                           allow_down;
  logic                           allow_up;
  logic signed [Q_WIDTH-1:0]      best_c;
  action_t                        greedy_c;
  action_t                        pick_c;
  action_t                        act_c;
  logic                           use_greedy_c;
  logic [LW-1:0]                  nlev_c;
  logic [Q_WIDTH-1:0]             best_mag;
  logic [Q_WIDTH:0]               diff_mag;
  logic [PGW:0]                   rnd_g_sum;
  logic [PAW:0]                   rnd_a_sum;
  logic signed [UW-1:0]           term_g;
  logic signed [UW-1:0]           term_a;
  logic signed [UW-1:0]           target_sum;
  logic signed [Q_WIDTH-1:0]      target_sat;
  logic signed [Q_WIDTH-1:0]      entry_q;
  logic signed [UW-1:0]           newq_sum;
  logic signed [Q_WIDTH-1:0]      newq_sat;
  logic [ROW_W-1:0]               wb_row;
  logic signed [DW-1:0]           drive_sum;
  logic signed [DRIVE_W-1:0]      drive_sat;

  // table memory
  logic                           ram_we;
  logic [LW-1:0]                  ram_waddr;
  logic [ROW_W-1:0]               ram_wdata;
  logic [LW-1:0]                  ram_raddr;
  logic [ROW_W-1:0]               ram_rdata;

  // --------------------------------------------------------------------------
  // configuration write port
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_learn_rate <= LEARN_RATE_RST;
      cfg_discount   <= DISCOUNT_RST;
      cfg_explore    <= EXPLORE_RST;
      cfg_num_levels <= NUM_LEVELS_RST;
      cfg_q_initial  <= '0;
      cfg_init_level <= '0;
      cfg_omega_min  <= '0;
      cfg_omega_step <= OMEGA_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_LEARN_RATE: cfg_learn_rate <= cfg_data[FRAC_W-1:0];
        CFG_DISCOUNT:   cfg_discount   <= cfg_data[FRAC_W-1:0];
        CFG_EXPLORE:    cfg_explore    <= cfg_data[FRAC_W-1:0];
        CFG_NUM_LEVELS: cfg_num_levels <= cfg_data[NUM_LEVELS_W-1:0];
        CFG_Q_INITIAL:  cfg_q_initial  <= cfg_data[Q_INIT_W-1:0];
        CFG_INIT_LEVEL: cfg_init_level <= cfg_data[INIT_LEVEL_W-1:0];
        CFG_OMEGA_MIN:  cfg_omega_min  <= cfg_data[DRIVE_W-1:0];
        CFG_OMEGA_STEP: cfg_omega_step <= cfg_data[OMEGA_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // register clamps: ladder top, start level, fractions, q_initial
  // --------------------------------------------------------------------------
  assign nl_ext = CW'(cfg_num_levels);
  assign il_ext = CW'(cfg_init_level);

  always_comb begin
    if (nl_ext < CW'(2)) begin
      top_level = LW'(1);
    end else if (nl_ext > CW'(MAX_LEVELS)) begin
      top_level = LW'(MAX_LEVELS - 1);
    end else begin
      top_level = LW'(nl_ext - CW'(1));
    end
  end

  assign start_level = (il_ext > CW'(top_level)) ? top_level : LW'(il_ext);

  assign alpha = (cfg_learn_rate > FRAC_ONE) ? FRAC_ONE : cfg_learn_rate;
  assign gamma = (cfg_discount > FRAC_ONE) ? FRAC_ONE : cfg_discount;

  assign qi_ext = EW'(cfg_q_initial);

  always_comb begin
    if (qi_ext > QI_MAX) begin
      q_init_sat = Q_WIDTH'(QI_MAX);
    end else if (qi_ext < QI_MIN) begin
      q_init_sat = Q_WIDTH'(QI_MIN);
    end else begin
      q_init_sat = Q_WIDTH'(qi_ext);
    end
  end

  // level reached by the previous action, clamped to the ladder
  assign move_sum   = (LW + 1)'(prev_level) + (LW + 1)'(prev_action);
  assign move_dec   = (move_sum == '0) ? '0 : move_sum - (LW + 1)'(1);
  assign move_level = (move_dec > (LW + 1)'(top_level)) ? top_level : LW'(move_dec);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign out_slot_free = !out_valid || !out_stall;
  assign in_take       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = first_pending ? ST_INIT : ST_ROW;
        end
      end
      ST_INIT:     state_next = ST_INIT_OUT;
      ST_INIT_OUT: begin
        if (out_slot_free) begin
          load_out   = 1'b1;
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_cnt == FILL_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_ROW:  state_next = ST_PREV;
      ST_PREV: state_next = ST_TGT;
      ST_TGT:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MULA;
      ST_MULA: state_next = ST_WB;
      ST_WB: begin
        if (out_slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // agent state: first-item flag, previous level and action
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      prev_level    <= '0;
      prev_action   <= ACT_HOLD;
    end else if (in_take && first_pending) begin
      first_pending <= 1'b0;
      prev_level    <= start_level;
      prev_action   <= ACT_HOLD;
    end else if (state == ST_WB && load_out) begin
      prev_level    <= level_reg;
      prev_action   <= act_reg;
    end
  end

  // --------------------------------------------------------------------------
  // current row: greedy search, random pick, action choice
  // --------------------------------------------------------------------------
  assign q_r0 = ram_rdata[0 +: Q_WIDTH];
  assign q_r1 = ram_rdata[Q_WIDTH +: Q_WIDTH];
  assign q_r2 = ram_rdata[2 * Q_WIDTH +: Q_WIDTH];

  assign allow_down = (level_reg != '0);
  assign allow_up   = (level_reg != top_level);

  // tie goes to the lowest action
  always_comb begin
    best_c   = q_r1;
    greedy_c = ACT_HOLD;
    if (allow_down) begin
      best_c   = q_r0;
      greedy_c = ACT_DOWN;
      if (q_r1 > q_r0) begin
        best_c   = q_r1;
        greedy_c = ACT_HOLD;
      end
    end
    if (allow_up && (q_r2 > best_c)) begin
      best_c   = q_r2;
      greedy_c = ACT_UP;
    end
  end

  always_comb begin
    if (!allow_down) begin
      pick_c = (rpick_reg < PICK_HALF) ? ACT_HOLD : ACT_UP;
    end else if (!allow_up) begin
      pick_c = (rpick_reg < PICK_HALF) ? ACT_DOWN : ACT_HOLD;
    end else if (rpick_reg < PICK_THIRD) begin
      pick_c = ACT_DOWN;
    end else if (rpick_reg < PICK_TWO_THIRDS) begin
      pick_c = ACT_HOLD;
    end else begin
      pick_c = ACT_UP;
    end
  end

  assign use_greedy_c = FRAC_W'(rexp_reg) > cfg_explore;
  assign act_c        = use_greedy_c ? greedy_c : pick_c;
  assign nlev_c       = LW'((LW + 1)'(level_reg) + (LW + 1)'(act_c) - (LW + 1)'(1));

  // --------------------------------------------------------------------------
  // update arithmetic: magnitudes, rounding, saturation
  // --------------------------------------------------------------------------
  assign best_mag = best_reg[Q_WIDTH-1] ? Q_WIDTH'(-best_reg) : Q_WIDTH'(best_reg);
  assign diff_mag = diff_reg[Q_WIDTH] ? (Q_WIDTH + 1)'(-diff_reg) : (Q_WIDTH + 1)'(diff_reg);

  // round to nearest, ties away from zero, on the magnitude
  assign rnd_g_sum = (PGW + 1)'(prod_g) + (PGW + 1)'(FRAC_HALF);
  assign rnd_a_sum = (PAW + 1)'(prod_a) + (PAW + 1)'(FRAC_HALF);

  always_comb begin
    term_g = $signed(UW'(rnd_g_sum[PGW:FRAC_SHIFT]));
    if (best_neg) begin
      term_g = -term_g;
    end
    term_a = $signed(UW'(rnd_a_sum[PAW:FRAC_SHIFT]));
    if (diff_neg) begin
      term_a = -term_a;
    end
  end

  assign target_sum = UW'(reward_reg) + term_g;

  always_comb begin
    if (target_sum > QU_MAX) begin
      target_sat = Q_WIDTH'(QU_MAX);
    end else if (target_sum < QU_MIN) begin
      target_sat = Q_WIDTH'(QU_MIN);
    end else begin
      target_sat = Q_WIDTH'(target_sum);
    end
  end

  // entry of the previous action in the previous row
  always_comb begin
    case (prev_action)
      ACT_DOWN: entry_q = prev_row_reg[0 +: Q_WIDTH];
      ACT_HOLD: entry_q = prev_row_reg[Q_WIDTH +: Q_WIDTH];
      ACT_UP:   entry_q = prev_row_reg[2 * Q_WIDTH +: Q_WIDTH];
      default:  entry_q = prev_row_reg[Q_WIDTH +: Q_WIDTH];
    endcase
  end

  assign newq_sum = UW'(entry_q) + term_a;

  always_comb begin
    if (newq_sum > QU_MAX) begin
      newq_sat = Q_WIDTH'(QU_MAX);
    end else if (newq_sum < QU_MIN) begin
      newq_sat = Q_WIDTH'(QU_MIN);
    end else begin
      newq_sat = Q_WIDTH'(newq_sum);
    end
  end

  // previous row with the updated entry merged in
  always_comb begin
    wb_row = prev_row_reg;
    case (prev_action)
      ACT_DOWN: wb_row[0 +: Q_WIDTH]           = newq_sat;
      ACT_HOLD: wb_row[Q_WIDTH +: Q_WIDTH]     = newq_sat;
      ACT_UP:   wb_row[2 * Q_WIDTH +: Q_WIDTH] = newq_sat;
      default:  wb_row = prev_row_reg;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath registers, stepped by the sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          reward_reg <= reward_value;
          rexp_reg   <= rand_explore;
          rpick_reg  <= rand_pick;
          if (first_pending) begin
            nlev_reg    <= start_level;
            act_reg     <= ACT_HOLD;
            greedy_flag <= 1'b0;
            first_flag  <= 1'b1;
            best_reg    <= '0;
            q0_reg      <= q_init_sat;
            fill_cnt    <= '0;
          end else begin
            level_reg  <= move_level;
            first_flag <= 1'b0;
          end
        end
      end
      ST_FILL: fill_cnt <= fill_cnt + LW'(1);
      ST_ROW: begin
        best_reg    <= best_c;
        act_reg     <= act_c;
        greedy_flag <= use_greedy_c;
        nlev_reg    <= nlev_c;
      end
      ST_PREV: begin
        prev_row_reg <= ram_rdata;
        prod_g       <= PGW'(best_mag) * PGW'(gamma);
        best_neg     <= best_reg[Q_WIDTH-1];
      end
      ST_TGT:  target_reg <= target_sat;
      ST_DIFF: diff_reg <= (Q_WIDTH + 1)'(target_reg) - (Q_WIDTH + 1)'(entry_q);
      ST_MULA: begin
        prod_a   <= PAW'(diff_mag) * PAW'(alpha);
        diff_neg <= diff_reg[Q_WIDTH];
      end
      default: ;
    endcase
  end

  // drive value of the result level: multiply, then add and saturate
  always_ff @(posedge clk) begin
    drive_prod <= DPW'(nlev_reg) * DPW'(cfg_omega_step);
  end

  assign drive_sum = DW'(cfg_omega_min) + $signed(DW'(drive_prod));

  always_comb begin
    if (drive_sum > DRV_MAX) begin
      drive_sat = DRIVE_W'(DRV_MAX);
    end else if (drive_sum < DRV_MIN) begin
      drive_sat = DRIVE_W'(DRV_MIN);
    end else begin
      drive_sat = DRIVE_W'(drive_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Q table: row fill after the first item, row write-back after the others
  // --------------------------------------------------------------------------
  assign ram_we    = (state == ST_FILL) || (state == ST_WB && load_out);
  assign ram_waddr = (state == ST_FILL) ? fill_cnt : prev_level;
  assign ram_wdata = (state == ST_FILL) ? {3{q0_reg}} : wb_row;
  assign ram_raddr = (state == ST_IDLE) ? move_level : prev_level;

  tqlla_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_LEVELS)
  ) u_qtab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_level     <= LEVEL_OUT_W'(nlev_reg);
      chosen_action <= act_reg;
      was_greedy    <= greedy_flag;
      was_first     <= first_flag;
      best_q        <= BEST_Q_W'(best_reg);
      drive_value   <= drive_sat;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `TQLLA_ASSERT_IMP(a_fill_after_first, clk, rst, state == ST_FILL, !first_pending,
                    "table fill running before the first item")
  `TQLLA_ASSERT_IMP(a_ram_write_window, clk, rst, ram_we, state == ST_FILL || state == ST_WB,
                    "table written outside fill or write-back")
  `TQLLA_ASSERT_IMP(a_out_kind, clk, rst, out_valid, !(was_greedy && was_first),
                    "first-item result flagged as greedy")
  `TQLLA_ASSERT_NXT(a_load_shows, clk, rst, load_out, out_valid,
                    "loaded result not presented")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the epsilon-greedy Q-learning level agent.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the Q table, the ladder position
// and the register file. It predicts one decision per transfer taken on the
// input channel and checks each result transfer against the oldest
// prediction. The stimulus starts with a short walk over a four-level ladder
// that hits the ladder ends, the pick boundaries and rewards of both signs.
// Random phases follow under several register settings, the extremes among
// them. Both channels idle at random, except for one phase with none.
// ----------------------------------------------------------------------------
module tb_top;
  import tqlla_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = MAX_LEVELS_DEF + 16;
  localparam int IDLE_PCT     = 36;
  localparam int PHASE_ITEMS  = 105;

  localparam longint Q_HI = (64'sd1 <<< (Q_WIDTH_DEF - 1)) - 1;
  localparam longint Q_LO = -Q_HI - 1;
  localparam longint DRIVE_HI = 64'sd2147483647;
  localparam longint DRIVE_LO = -64'sd2147483648;

  // rand_pick values on either side of the 1/3, 1/2 and 2/3 splits
  localparam logic [RAND_W-1:0] PICK_SPLITS [8] = '{
    16'd0, 16'd21845, 16'd21846, 16'd32767, 16'd32768, 16'd43690, 16'd43691, 16'hFFFF
  };

  typedef struct packed {
    logic [LEVEL_OUT_W-1:0] level;
    action_t                action;
    logic                   greedy;
    logic                   first;
    logic [BEST_Q_W-1:0]    best;
    logic [DRIVE_W-1:0]     drive;
  } decision_t;

  // Decision predictor and result checker
  class decision_scoreboard;
    decision_t            pending[$];
    logic [CFG_DATA_W-1:0] regs [8];
    longint               q_val [MAX_LEVELS_DEF * 3];
    int unsigned          last_level;
    action_t              last_action;
    bit                   first_due;
    int unsigned          failures;
    int unsigned          checked;
    int unsigned          greedy_count;
    int unsigned          explore_count;
    int unsigned          clipped;

    function new();
      regs[CFG_LEARN_RATE] = 32'(LEARN_RATE_RST);
      regs[CFG_DISCOUNT]   = 32'(DISCOUNT_RST);
      regs[CFG_EXPLORE]    = 32'(EXPLORE_RST);
      regs[CFG_NUM_LEVELS] = 32'(NUM_LEVELS_RST);
      regs[CFG_Q_INITIAL]  = '0;
      regs[CFG_INIT_LEVEL] = '0;
      regs[CFG_OMEGA_MIN]  = '0;
      regs[CFG_OMEGA_STEP] = 32'(OMEGA_STEP_RST);
      foreach (q_val[i]) q_val[i] = 0;
      last_level  = 0;
      last_action = ACT_HOLD;
      first_due   = 1'b1;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      int unsigned w;
      case (idx)
        CFG_LEARN_RATE, CFG_DISCOUNT, CFG_EXPLORE: w = FRAC_W;
        CFG_NUM_LEVELS: w = NUM_LEVELS_W;
        CFG_Q_INITIAL:  w = Q_INIT_W;
        CFG_INIT_LEVEL: w = INIT_LEVEL_W;
        CFG_OMEGA_MIN:  w = DRIVE_W;
        default:        w = OMEGA_STEP_W;
      endcase
      regs[idx] = data & 32'((64'd1 << w) - 1);
    endfunction

    function int unsigned ladder_size();
      int unsigned n;
      n = regs[CFG_NUM_LEVELS];
      if (n < 2) n = 2;
      if (n > MAX_LEVELS_DEF) n = MAX_LEVELS_DEF;
      return n;
    endfunction

    // alpha and gamma stop at 1.0
    function longint frac(cfg_index_t idx);
      return (regs[idx] > 32'(FRAC_ONE)) ? longint'(FRAC_ONE) : longint'(regs[idx]);
    endfunction

    function longint sat_q(longint v);
      if (v > Q_HI) begin
        clipped++;
        return Q_HI;
      end
      if (v < Q_LO) begin
        clipped++;
        return Q_LO;
      end
      return v;
    endfunction

    // x * f / 2^16, rounded to nearest, halves away from zero
    function longint scale(longint x, longint f);
      longint mag, p;
      mag = (x < 0) ? -x : x;
      p = (mag * f + 32768) >>> FRAC_SHIFT;
      return (x < 0) ? -p : p;
    endfunction

    function logic [DRIVE_W-1:0] drive_at(int unsigned lvl);
      longint v;
      v = longint'($signed(regs[CFG_OMEGA_MIN])) + longint'(lvl) * longint'(regs[CFG_OMEGA_STEP]);
      if (v > DRIVE_HI) v = DRIVE_HI;
      if (v < DRIVE_LO) v = DRIVE_LO;
      return v[DRIVE_W-1:0];
    endfunction

    // Predict the result of one accepted decision transfer
    function void note_decision(logic signed [REWARD_W-1:0] reward,
                                logic [RAND_W-1:0] explore_draw,
                                logic [RAND_W-1:0] pick_draw);
      decision_t   d;
      int unsigned nl, lvl, lo, hi, slot;
      action_t     greedy_act, pick_act, act;
      longint      s, best, target, updated, q0;
      bit          take_greedy;
      nl = ladder_size();
      d  = '0;
      if (first_due) begin
        // start-up transfer: load the table, inputs are ignored
        q0 = sat_q(longint'($signed(regs[CFG_Q_INITIAL][Q_INIT_W-1:0])));
        foreach (q_val[i]) q_val[i] = q0;
        lvl = regs[CFG_INIT_LEVEL];
        if (lvl > nl - 1) lvl = nl - 1;
        last_level  = lvl;
        last_action = ACT_HOLD;
        first_due   = 1'b0;
        d.level  = lvl[LEVEL_OUT_W-1:0];
        d.action = ACT_HOLD;
        d.first  = 1'b1;
        d.drive  = drive_at(lvl);
        pending.push_back(d);
        return;
      end

      // move by the last action, kept on the ladder in use
      s = longint'(last_level) + longint'(last_action) - 1;
      if (s < 0) s = 0;
      if (s > longint'(nl) - 1) s = longint'(nl) - 1;
      lvl = 32'(s);

      // greedy action over the allowed ones, lowest wins a tie
      lo = (lvl == 0) ? 1 : 0;
      hi = (lvl == nl - 1) ? 1 : 2;
      greedy_act = action_t'(lo);
      best = q_val[lvl * 3 + lo];
      for (int a = lo + 1; a <= hi; a++) begin
        if (q_val[lvl * 3 + a] > best) begin
          best = q_val[lvl * 3 + a];
          greedy_act = action_t'(a);
        end
      end

      // random action by rand_pick
      if (lo == 1)
        pick_act = (int'(pick_draw) < FRAC_HALF) ? ACT_HOLD : ACT_UP;
      else if (hi == 1)
        pick_act = (int'(pick_draw) < FRAC_HALF) ? ACT_DOWN : ACT_HOLD;
      else if (int'(pick_draw) * 3 < 65536)
        pick_act = ACT_DOWN;
      else if (int'(pick_draw) * 3 < 131072)
        pick_act = ACT_HOLD;
      else
        pick_act = ACT_UP;

      // learning update of the previous entry
      slot = (last_level % MAX_LEVELS_DEF) * 3 + (int'(last_action) % 3);
      target = sat_q(longint'(reward) + scale(best, frac(CFG_DISCOUNT)));
      updated = q_val[slot] + scale(target - q_val[slot], frac(CFG_LEARN_RATE));
      q_val[slot] = sat_q(updated);

      take_greedy = explore_draw > regs[CFG_EXPLORE];
      act = take_greedy ? greedy_act : pick_act;
      if (take_greedy) greedy_count++;
      else explore_count++;
      last_level  = lvl;
      last_action = act;

      lvl = lvl + int'(act) - 1;
      d.level  = lvl[LEVEL_OUT_W-1:0];
      d.action = act;
      d.greedy = take_greedy;
      d.best   = best[BEST_Q_W-1:0];
      d.drive  = drive_at(lvl);
      pending.push_back(d);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_decision(logic [LEVEL_OUT_W-1:0] lvl, logic [ACTION_W-1:0] act,
                                 logic greedy, logic first,
                                 logic [BEST_Q_W-1:0] best, logic [DRIVE_W-1:0] drive);
      decision_t want;
      bit        bad;
      checked++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result with no decision outstanding (level %0d action %0d)",
                   lvl, act);
        return;
      end
      want = pending.pop_front();
      bad = (lvl !== want.level) || (act !== want.action) || (greedy !== want.greedy) ||
            (first !== want.first) || (best !== want.best) || (drive !== want.drive);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: result %0d expected level %0d action %0d greedy %0b first %0b",
                   checked, want.level, want.action, want.greedy, want.first);
          $display("       best_q %0d drive %0d; got level %0d action %0d greedy %0b",
                   $signed(want.best), $signed(want.drive), lvl, act, greedy);
          $display("       first %0b best_q %0d drive %0d",
                   first, $signed(best), $signed(drive));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [REWARD_W-1:0]   reward_value = '0;
  logic [RAND_W-1:0]            rand_explore = '0;
  logic [RAND_W-1:0]            rand_pick    = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [LEVEL_OUT_W-1:0]       new_level;
  logic [ACTION_W-1:0]          chosen_action;
  logic                         was_greedy;
  logic                         was_first;
  logic signed [BEST_Q_W-1:0]   best_q;
  logic signed [DRIVE_W-1:0]    drive_value;

  decision_scoreboard sb;
  bit                 steady_flow    = 1'b0;
  int unsigned        settings_count = 0;
  int unsigned        cycle_count    = 0;

  tabular_q_learning_level_agent i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .reward_value  (reward_value),
    .rand_explore  (rand_explore),
    .rand_pick     (rand_pick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_level     (new_level),
    .chosen_action (chosen_action),
    .was_greedy    (was_greedy),
    .was_first     (was_first),
    .best_q        (best_q),
    .drive_value   (drive_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_decision(new_level, chosen_action, was_greedy, was_first, best_q, drive_value);
    out_stall <= !rst && !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // One decision transfer, with an optional idle gap ahead of it
  task automatic send_decision(logic signed [REWARD_W-1:0] reward,
                               logic [RAND_W-1:0] explore_draw,
                               logic [RAND_W-1:0] pick_draw);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    reward_value <= reward;
    rand_explore <= explore_draw;
    rand_pick    <= pick_draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_decision(reward, explore_draw, pick_draw);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic cfg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // All results back, then room for the table fill or a last write-back
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_DATA_W-1:0] learn, logic [CFG_DATA_W-1:0] disc,
                                logic [CFG_DATA_W-1:0] expl, logic [CFG_DATA_W-1:0] levels,
                                logic [CFG_DATA_W-1:0] omin, logic [CFG_DATA_W-1:0] ostep);
    wait_idle();
    cfg_write(CFG_LEARN_RATE, learn);
    cfg_write(CFG_DISCOUNT, disc);
    cfg_write(CFG_EXPLORE, expl);
    cfg_write(CFG_NUM_LEVELS, levels);
    cfg_write(CFG_OMEGA_MIN, omin);
    cfg_write(CFG_OMEGA_STEP, ostep);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // Random decisions; explore and pick draws sometimes sit on a boundary
  task automatic run_random(int count, bit pos_reward);
    logic signed [REWARD_W-1:0] reward;
    logic [RAND_W-1:0]          explore_draw, pick_draw;
    for (int k = 0; k < count; k++) begin
      if (pos_reward) reward = REWARD_W'($urandom_range(0, 65536));
      else reward = REWARD_W'(int'($urandom_range(0, 131072)) - 65536);
      explore_draw = RAND_W'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: explore_draw = '0;
          1: explore_draw = sb.regs[CFG_EXPLORE][RAND_W-1:0];
          2: explore_draw = sb.regs[CFG_EXPLORE][RAND_W-1:0] + 1'b1;
          default: explore_draw = '1;
        endcase
      end
      pick_draw = ($urandom_range(0, 7) == 0) ? PICK_SPLITS[$urandom_range(0, 7)] :
                                                RAND_W'($urandom);
      send_decision(reward, explore_draw, pick_draw);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] q_init;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Four-level ladder, start level above the top, alpha and gamma at 1.0
    write_settings(32'(FRAC_ONE), 32'(FRAC_ONE), 32'd32768, 32'd4, -32'sd196608, 32'd65536);
    @(posedge clk);
    case ($urandom_range(0, 2))
      0: q_init = 32'h007F_FFFF;
      1: q_init = 32'h0080_0000;
      default: q_init = $urandom;
    endcase
    cfg_write(CFG_Q_INITIAL, q_init);
    cfg_write(CFG_INIT_LEVEL, 32'd63);
    cfg_valid <= 1'b0;

    // Directed walk: start-up transfer, then explore draws of zero that
    // steer along the ladder across every pick split, then greedy steps
    send_decision(18'sd65536, 16'hFFFF, 16'hFFFF);
    send_decision(18'sd65536, 16'd0, 16'd0);
    send_decision(-18'sd65536, 16'd0, 16'd0);
    send_decision(18'sd1, 16'd0, 16'd21845);
    send_decision(-18'sd1, 16'd0, 16'd21846);
    send_decision(18'sd0, 16'd0, 16'd32767);
    send_decision(18'sd65536, 16'd0, 16'd32768);
    send_decision(18'sd0, 16'd0, 16'd43690);
    send_decision(18'sd0, 16'd0, 16'd43691);
    send_decision(18'sd0, 16'd0, 16'hFFFF);
    send_decision(-18'sd65536, 16'd0, 16'd32767);
    send_decision(18'sd0, 16'd0, 16'hFFFF);
    send_decision(18'sd0, 16'd0, 16'd32768);
    // explore draw equal to the threshold still explores
    send_decision(18'sd65536, 16'd32768, 16'd0);
    send_decision(18'sd65536, 16'd32769, 16'd0);
    send_decision(-18'sd65536, 16'hFFFF, 16'hFFFF);
    send_decision(18'sd32767, 16'hFFFF, 16'd0);
    send_decision(-18'sd32768, 16'd1, 16'd21846);
    send_decision(18'sd0, 16'hFFFF, 16'd12345);
    in_valid <= 1'b0;

    // Register values after reset, full ladder
    write_settings(32'(LEARN_RATE_RST), 32'(DISCOUNT_RST), 32'(EXPLORE_RST), 32'd64,
                   $urandom, $urandom_range(0, 1 << 20));
    run_random(PHASE_ITEMS, 1'b0);

    // No learning, greedy unless the explore draw is zero, shortest ladder (pulls the level back), lowest drive
    write_settings(32'd0, 32'd0, 32'd0, 32'd2, 32'h8000_0000, 32'd0);
    run_random(PHASE_ITEMS, 1'b0);

    // Full-rate learning on positive rewards, drive pinned high, no idling
    steady_flow = 1'b1;
    write_settings(32'(FRAC_ONE), 32'(FRAC_ONE), 32'd20000, 32'd64,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(PHASE_ITEMS, 1'b1);
    steady_flow = 1'b0;

    // Fractions above 1.0, ladder length of zero
    write_settings(32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'd0, $urandom, $urandom_range(0, 1 << 16));
    run_random(PHASE_ITEMS, 1'b0);

    // Wide data words, ladder length over the maximum, always exploring
    write_settings($urandom, $urandom, 32'd65535, 32'hFFFF_FF7F, $urandom, $urandom);
    run_random(PHASE_ITEMS, 1'b0);

    // Random settings on a short ladder
    write_settings($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536),
                   $urandom_range(3, 10), $urandom, $urandom_range(0, 1 << 24));
    run_random(PHASE_ITEMS, 1'b0);

    wait_idle();
    $display("Checked %0d decisions over %0d register settings: %0d greedy, %0d exploring,",
             sb.checked, settings_count, sb.greedy_count, sb.explore_count);
    $display("%0d saturated Q values, %0d mismatches, %0d results missing.",
             sb.clipped, sb.failures, sb.pending.size());
    if (sb.failures == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
